>>> rtl/core/rbs_pkg.sv
// shared types, widths and constants for the ray versus box slab test
package rbs_pkg;

  localparam int COORD_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int DIST_W     = 48;
  localparam int NUM_AXES   = 3;
  localparam int NUM_LANES  = 2 * NUM_AXES;
  localparam int DIV_NUM_W  = 48;
  localparam int DIV_DEN_W  = 32;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = DIV_NUM_W / DIV_BITS;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIST_W-1:0]  dist_t;

  localparam dist_t START_FAR  = 48'sd65536000000;
  localparam dist_t START_NEAR = -48'sd65536000000;
  localparam dist_t DIST_MAX   = {1'b0, {(DIST_W-1){1'b1}}};
  localparam dist_t DIST_MIN   = {1'b1, {(DIST_W-1){1'b0}}};

  typedef struct packed {
    coord_t org_x;
    coord_t org_y;
    coord_t org_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t box_min_x;
    coord_t box_max_x;
    coord_t box_min_y;
    coord_t box_max_y;
    coord_t box_min_z;
    coord_t box_max_z;
  } ray_box_t;

  typedef struct packed {
    logic  hit;
    dist_t t_near;
  } hit_t;

  // per item flags that ride alongside the divider lanes
  typedef struct packed {
    logic [NUM_AXES-1:0] par;
    logic                rej;
  } side_t;

  // apply the quotient sign and clamp to the distance range
  function automatic dist_t sat_dist(input logic [DIV_NUM_W-1:0] mag, input logic neg);
    logic signed [DIV_NUM_W:0] sv;
    dist_t                     res;
    sv = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (sv > $signed({1'b0, DIST_MAX})) begin
      res = DIST_MAX;
    end else if (sv < $signed({1'b1, DIST_MIN})) begin
      res = DIST_MIN;
    end else begin
      res = sv[DIST_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/core/rbs_in_if.sv
// input channel: one ray and one box per beat
interface rbs_in_if;
  import rbs_pkg::*;
  logic     valid;
  logic     ready;
  ray_box_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/rbs_out_if.sv
// output channel: hit flag and entry distance per beat
interface rbs_out_if;
  import rbs_pkg::*;
  logic valid;
  logic ready;
  hit_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/rbs_sdiv.sv
// pipelined unsigned restoring divider, four quotient bits per stage, sign carried along
module rbs_sdiv (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [rbs_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [rbs_pkg::DIV_DEN_W-1:0] den_i,
  input  logic                          neg_i,
  output logic [rbs_pkg::DIV_NUM_W-1:0] quo_o,
  output logic                          neg_o
);
  import rbs_pkg::*;

  logic [DIV_DEN_W-1:0] rem_q [DIV_STAGES];
  logic [DIV_NUM_W-1:0] nq_q  [DIV_STAGES];
  logic [DIV_DEN_W-1:0] den_q [DIV_STAGES];
  logic                 neg_q [DIV_STAGES];
  logic [DIV_DEN_W-1:0] rem_d [DIV_STAGES];
  logic [DIV_NUM_W-1:0] nq_d  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_DEN_W-1:0] rem_in;
    logic [DIV_NUM_W-1:0] nq_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic                 neg_in;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign nq_in  = nq_q[s-1];
      assign den_in = den_q[s-1];
      assign neg_in = neg_q[s-1];
    end

    // remainder shifts in dividend bits from the top, quotient bits enter at the bottom
    always_comb begin
      logic [DIV_DEN_W:0]   wide;
      logic [DIV_DEN_W-1:0] rem;
      logic [DIV_NUM_W-1:0] nq;
      rem = rem_in;
      nq  = nq_in;
      for (int k = 0; k < DIV_BITS; k++) begin
        wide = {rem, nq[DIV_NUM_W-1]};
        nq   = {nq[DIV_NUM_W-2:0], 1'b0};
        if (wide >= {1'b0, den_in}) begin
          wide  = wide - {1'b0, den_in};
          nq[0] = 1'b1;
        end
        rem = wide[DIV_DEN_W-1:0];
      end
      rem_d[s] = rem;
      nq_d[s]  = nq;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d[s];
        nq_q[s]  <= nq_d[s];
        den_q[s] <= den_in;
        neg_q[s] <= neg_in;
      end
    end
  end

  assign quo_o = nq_q[DIV_STAGES-1];
  assign neg_o = neg_q[DIV_STAGES-1];

endmodule

>>> rtl/core/ray_box_slab_test.sv
// ray versus axis-aligned box slab test, fully pipelined
//
//  channel  dir  handshake       beat contents
//  in_i     in   valid / ready   ray origin, direction, box bounds (Q16.16)
//  out_o    out  valid / ready   hit flag, entry distance (Q32.16)
//
// one beat accepted per cycle unless the output stalls; six parallel divider lanes
// resolve four quotient bits per stage.
// the whole pipeline advances together whenever the output register is empty
// or being taken; a stall freezes every stage, so nothing is lost or repeated.
// reset clears only the valid bits.
module ray_box_slab_test (
  input  logic      clk_i,
  input  logic      rst_ni,
  rbs_in_if.sink    in_i,
  rbs_out_if.source out_o
);
  import rbs_pkg::*;

  localparam int LAT = DIV_STAGES + 4;

  logic           en;
  logic [LAT-1:0] valid_q;

  assign en       = !valid_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LAT-2:0], in_i.valid};
    end
  end

  // stage 1: slab differences, magnitudes and signs
  coord_t org [NUM_AXES];
  coord_t dir [NUM_AXES];
  coord_t lo  [NUM_AXES];
  coord_t hi  [NUM_AXES];

  always_comb begin
    org[0] = in_i.payload.org_x;  dir[0] = in_i.payload.dir_x;
    org[1] = in_i.payload.org_y;  dir[1] = in_i.payload.dir_y;
    org[2] = in_i.payload.org_z;  dir[2] = in_i.payload.dir_z;
    lo[0]  = in_i.payload.box_min_x;  hi[0] = in_i.payload.box_max_x;
    lo[1]  = in_i.payload.box_min_y;  hi[1] = in_i.payload.box_max_y;
    lo[2]  = in_i.payload.box_min_z;  hi[2] = in_i.payload.box_max_z;
  end

  logic [DIV_NUM_W-1:0] num_d [NUM_LANES];
  logic [DIV_DEN_W-1:0] den_d [NUM_LANES];
  logic                 neg_d [NUM_LANES];
  side_t                side_d;

  always_comb begin
    logic signed [COORD_W:0] diff;
    logic [COORD_W-1:0]      mag;
    logic [DIV_DEN_W-1:0]    dmag;
    side_d = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      dmag = dir[a][COORD_W-1] ? -dir[a] : dir[a];
      side_d.par[a] = (dir[a] == '0);
      if ((dir[a] == '0) && ((org[a] < lo[a]) || (org[a] > hi[a]))) begin
        side_d.rej = 1'b1;
      end
      for (int b = 0; b < 2; b++) begin
        diff = (b == 0) ? ($signed({lo[a][COORD_W-1], lo[a]}) -
                           $signed({org[a][COORD_W-1], org[a]}))
                        : ($signed({hi[a][COORD_W-1], hi[a]}) -
                           $signed({org[a][COORD_W-1], org[a]}));
        mag = diff[COORD_W] ? ~diff[COORD_W-1:0] + 1'b1 : diff[COORD_W-1:0];
        num_d[2*a+b] = {mag, {FRAC_W{1'b0}}};
        den_d[2*a+b] = dmag;
        neg_d[2*a+b] = diff[COORD_W] ^ dir[a][COORD_W-1];
      end
    end
  end

  logic [DIV_NUM_W-1:0] num1_q [NUM_LANES];
  logic [DIV_DEN_W-1:0] den1_q [NUM_LANES];
  logic                 neg1_q [NUM_LANES];
  side_t                side_q [DIV_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      num1_q    <= num_d;
      den1_q    <= den_d;
      neg1_q    <= neg_d;
      side_q[0] <= side_d;
      for (int s = 1; s <= DIV_STAGES; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // divider lanes: even lanes hold the lower bound, odd lanes the upper
  logic [DIV_NUM_W-1:0] quo [NUM_LANES];
  logic                 qneg [NUM_LANES];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    rbs_sdiv u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num1_q[l]),
      .den_i (den1_q[l]),
      .neg_i (neg1_q[l]),
      .quo_o (quo[l]),
      .neg_o (qneg[l])
    );
  end

  // stage 3: sign, saturation and ordering of the two slab distances
  dist_t tlo3_q [NUM_AXES];
  dist_t thi3_q [NUM_AXES];
  side_t side3_q;

  always_ff @(posedge clk_i) begin
    dist_t ta;
    dist_t tb;
    if (en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        ta = sat_dist(quo[2*a], qneg[2*a]);
        tb = sat_dist(quo[2*a+1], qneg[2*a+1]);
        tlo3_q[a] <= (ta > tb) ? tb : ta;
        thi3_q[a] <= (ta > tb) ? ta : tb;
      end
      side3_q <= side_q[DIV_STAGES];
    end
  end

  // stage 4: narrow the interval over the axes that are not parallel
  dist_t near4_q;
  dist_t far4_q;
  logic  rej4_q;

  always_ff @(posedge clk_i) begin
    dist_t n;
    dist_t f;
    if (en) begin
      n = START_NEAR;
      f = START_FAR;
      for (int a = 0; a < NUM_AXES; a++) begin
        if (!side3_q.par[a]) begin
          if (tlo3_q[a] > n) n = tlo3_q[a];
          if (thi3_q[a] < f) f = thi3_q[a];
        end
      end
      near4_q <= n;
      far4_q  <= f;
      rej4_q  <= side3_q.rej;
    end
  end

  // output register
  hit_t res_q;

  always_ff @(posedge clk_i) begin
    logic ok;
    if (en) begin
      ok = !rej4_q && !(near4_q > far4_q) && !(far4_q < 0);
      res_q.hit    <= ok;
      res_q.t_near <= ok ? near4_q : '0;
    end
  end

  assign out_o.valid   = valid_q[LAT-1];
  assign out_o.payload = res_q;

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.payload.hit |-> out_o.payload.t_near == '0)
    else $error("miss beat carries a nonzero distance");

  a_near_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.hit |-> out_o.payload.t_near <= START_FAR)
    else $error("entry distance beyond interval start");

  a_near_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.hit |-> out_o.payload.t_near >= START_NEAR)
    else $error("entry distance below interval start");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[LAT-1] && !out_o.ready |=> $stable(valid_q) && $stable(res_q))
    else $error("pipeline moved during an output stall");
`endif

endmodule
